FILE: rtl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared types and constants for the priority ready bitmap
// Field widths, request and state codes, command struct, lowest-bit encoder.
// ----------------------------------------------------------------------------
package prb_pkg;

    localparam int PRIO_W          = 6;
    localparam int PRIO_CMP_W      = PRIO_W + 1;
    localparam int HANDLE_W        = 8;
    localparam int NUM_GROUPS      = 8;
    localparam int GROUP_W         = 3;
    localparam int LEVELS_PER_GRP  = 8;
    localparam int GROUP_SHIFT     = 3;
    localparam logic [GROUP_W-1:0] LEVEL_MASK = 3'h7;

    localparam int NUM_PRIOS_DEF   = 64;
    localparam int HANDLE_BITS_DEF = 8;

    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;

    typedef logic [LEVELS_PER_GRP-1:0] level_mask_t;
    typedef logic [NUM_GROUPS-1:0]     group_mask_t;

    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;   // latch request, start handle store read
        logic execute;   // update bitmaps, load result register
    } ctrl_cmd_t;

    // Index of the lowest set bit, 0 when no bit is set.
    function automatic logic [GROUP_W-1:0] low_bit8(input logic [7:0] v);
        logic [GROUP_W-1:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = GROUP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/priority_ready_bitmap_top.sv
// Flow: an accepted item passes through the EXEC state to the OUT state, where m_tvalid is high.
// Items: one item at a time; no new request is taken until the result has been accepted
//   on the result channel.
// Reset: aresetn low clears the sequencer and both ready bitmaps; the handle store
//   needs no clearing since a clear level bit marks its slot as empty.
// ----------------------------------------------------------------------------
// priority_ready_bitmap_top: two-level ready bitmap priority scheduler
// Adds or removes task handles at 64 priority levels and reports the most
// urgent ready level after each item.
// ----------------------------------------------------------------------------
module priority_ready_bitmap_top #(
    parameter int NUM_PRIOS   = prb_pkg::NUM_PRIOS_DEF,
    parameter int HANDLE_BITS = prb_pkg::HANDLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prb_pkg::S_TDATA_W-1:0]   s_tdata,  // [5:0] priority_req, [13:6] task_handle
    input  logic                            s_tuser,  // [0] req_type
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prb_pkg::M_TDATA_W-1:0]   m_tdata   // [7:0] removed_handle,
                                                      // [13:8] top_priority, [14] any_ready
);
    import prb_pkg::*;

    ctrl_cmd_t             cmd;
    logic [HANDLE_W-1:0]   removed_handle;
    logic [PRIO_W-1:0]     top_priority;
    logic                  any_ready;

    // Sequence one item at a time: capture, execute, hold result until taken
    prb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Unpack request fields straight from the bus; the datapath latches them on capture
    prb_datapath #(
        .NUM_PRIOS   (NUM_PRIOS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_req_type     (s_tuser),
        .in_priority_req (s_tdata[PRIO_W-1:0]),
        .in_task_handle  (s_tdata[PRIO_W+HANDLE_W-1:PRIO_W]),
        .removed_handle  (removed_handle),
        .top_priority    (top_priority),
        .any_ready       (any_ready)
    );

    // Pack the result, low field first, zero pad to the byte boundary
    assign m_tdata = {1'b0, any_ready, top_priority, removed_handle};

endmodule

FILE: rtl/prb_ctrl.sv
// ----------------------------------------------------------------------------
// prb_ctrl: sequencer for the priority ready bitmap
// Steps one item through capture, execute and result hand-off.
// ----------------------------------------------------------------------------
module prb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output prb_pkg::ctrl_cmd_t cmd
);
    import prb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides active together");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed next cycle");

endmodule

FILE: rtl/prb_datapath.sv
// ----------------------------------------------------------------------------
// prb_datapath: bitmaps, handle store and priority encode
// Holds the two-level ready bitmap, the handle memory and the result register.
// ----------------------------------------------------------------------------
module prb_datapath #(
    parameter int NUM_PRIOS   = prb_pkg::NUM_PRIOS_DEF,
    parameter int HANDLE_BITS = prb_pkg::HANDLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  prb_pkg::ctrl_cmd_t            cmd,
    input  logic                          in_req_type,
    input  logic [prb_pkg::PRIO_W-1:0]    in_priority_req,
    input  logic [prb_pkg::HANDLE_W-1:0]  in_task_handle,
    output logic [prb_pkg::HANDLE_W-1:0]  removed_handle,
    output logic [prb_pkg::PRIO_W-1:0]    top_priority,
    output logic                          any_ready
);
    import prb_pkg::*;

    localparam int IDX_W   = $clog2(NUM_PRIOS);
    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // Captured request
    logic                 req_type_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [STORE_W-1:0]   handle_reg;
    logic [STORE_W-1:0]   rd_data_reg;

    // Ready bitmaps
    group_mask_t          group_mask_reg;
    group_mask_t          group_mask_next;
    level_mask_t          level_mask_reg  [NUM_GROUPS];
    level_mask_t          level_mask_next [NUM_GROUPS];

    // Handle store; the level bit acts as its valid bit
    logic [STORE_W-1:0]   handle_mem [NUM_PRIOS];

    // Result register
    logic [HANDLE_W-1:0]  removed_reg;
    logic [HANDLE_W-1:0]  removed_next;
    logic [PRIO_W-1:0]    top_reg;
    logic [PRIO_W-1:0]    top_next;
    logic                 any_reg;

    logic [GROUP_W-1:0]   grp;
    logic [GROUP_W-1:0]   off;
    logic [GROUP_W-1:0]   top_grp;
    logic                 in_range;
    logic                 is_remove;
    logic                 slot_full;
    logic                 mem_wr;

    assign grp       = prio_reg[PRIO_W-1:GROUP_SHIFT];
    assign off       = prio_reg[GROUP_W-1:0] & LEVEL_MASK;
    assign in_range  = {1'b0, prio_reg} < PRIO_CMP_W'(NUM_PRIOS);
    assign is_remove = (req_type_reg == REQ_REMOVE);
    assign slot_full = level_mask_reg[grp][off];
    assign mem_wr    = cmd.execute && in_range && !is_remove;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg <= in_req_type;
            prio_reg     <= in_priority_req;
            handle_reg   <= in_task_handle[STORE_W-1:0];
        end
    end

    // Handle memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            handle_mem[prio_reg[IDX_W-1:0]] <= handle_reg;
        end
        if (cmd.capture) begin
            rd_data_reg <= handle_mem[in_priority_req[IDX_W-1:0]];
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            level_mask_next[g] = level_mask_reg[g];
        end
        if (in_range) begin
            level_mask_next[grp][off] = !is_remove;
        end
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_mask_next[g] = |level_mask_next[g];
        end
        top_grp  = low_bit8(group_mask_next);
        top_next = {top_grp, low_bit8(level_mask_next[top_grp])};
        // Empty slot reads as zero
        removed_next = (in_range && is_remove && slot_full) ? HANDLE_W'(rd_data_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_mask_reg <= '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                level_mask_reg[g] <= '0;
            end
        end else if (cmd.execute) begin
            group_mask_reg <= group_mask_next;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                level_mask_reg[g] <= level_mask_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            removed_reg <= removed_next;
            top_reg     <= top_next;
            any_reg     <= |group_mask_next;
        end
    end

    assign removed_handle = removed_reg;
    assign top_priority   = top_reg;
    assign any_ready      = any_reg;

    group_mask_t group_or;
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_or[g] = |level_mask_reg[g];
        end
    end

    a_group_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        group_mask_reg == group_or)
        else $error("group mask out of step with level masks");

    a_add_sets_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && in_range && !is_remove) |=> level_mask_reg[$past(grp)][$past(off)])
        else $error("add did not mark level ready");

    a_empty_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> (any_reg || (top_reg == '0)))
        else $error("nonzero top priority with empty queue");

endmodule

FILE: tb/tb_priority_ready_bitmap_top.sv
// ----------------------------------------------------------------------------
// tb_priority_ready_bitmap_top: self-checking bench for the ready bitmap
// Drives add and remove requests through the request stream, predicts every
// result from a private copy of the two-level bitmap and handle store, and
// compares each returned item field by field, with random source and sink
// idling and at full rate.
// ----------------------------------------------------------------------------
module tb_priority_ready_bitmap_top;

    import prb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 20;    // wait after the last expected result for stray items
    localparam int ITEMS_PER_RUN = 260;   // random items in each random phase
    localparam int MAX_PRINTS    = 100;

    // One predicted result item.
    typedef struct {
        logic [7:0] removed;
        logic [5:0] top;
        logic       any;
    } sched_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow bitmap, shadow handle store, queue of expected items
    // ------------------------------------------------------------------------
    class ready_queue_scoreboard;
        group_mask_t     grp_ready;
        level_mask_t     lvl_ready[8];
        logic [7:0]      handles[64];
        sched_result_t   awaited_results[$];
        int unsigned     mismatches;
        int unsigned     results_seen;

        function new();
            grp_ready = '0;
            foreach (lvl_ready[g]) lvl_ready[g] = '0;
            foreach (handles[p]) handles[p] = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Index of the lowest set bit, 0 for an empty mask.
        function int lowest_set(logic [7:0] v);
            for (int i = 0; i < 8; i++) begin
                if (v[i]) return i;
            end
            return 0;
        endfunction

        function logic [5:0] ready_top();
            int g;
            g = lowest_set(grp_ready);
            return 6'((g << 3) + lowest_set(lvl_ready[g]));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Apply one accepted request to the shadow state and queue its result.
        function void note_request(req_type_t op, logic [5:0] prio, logic [7:0] handle);
            sched_result_t r;
            int g;
            int b;
            g = prio[5:3];
            b = prio[2:0];
            r.removed = '0;
            if (op == REQ_ADD) begin
                handles[prio]   = handle;
                grp_ready[g]    = 1'b1;
                lvl_ready[g][b] = 1'b1;
            end else begin
                lvl_ready[g][b] = 1'b0;
                if (lvl_ready[g] == '0) grp_ready[g] = 1'b0;
                r.removed      = handles[prio];
                handles[prio]  = '0;
            end
            r.top = ready_top();
            r.any = (grp_ready != '0);
            awaited_results.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("ERROR result %0d: %s got %0d expected %0d",
                         results_seen, what, got, want);
        endtask

        // Compare one accepted result item with the oldest expectation.
        task check_result(logic [M_TDATA_W-1:0] word);
            sched_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, data", int'(word), 0);
            end else begin
                want = awaited_results.pop_front();
                if (word[7:0] !== want.removed)
                    report_mismatch("removed_handle", int'(word[7:0]), int'(want.removed));
                if (word[13:8] !== want.top)
                    report_mismatch("top_priority", int'(word[13:8]), int'(want.top));
                if (word[14] !== want.any)
                    report_mismatch("any_ready", int'(word[14]), int'(want.any));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [5:0] priority_req, [13:6] task_handle
    logic                   s_tuser;   // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [7:0] removed_handle, [13:8] top_priority,
                                       // [14] any_ready

    int unsigned send_idle_pct;   // chance per cycle that the source holds off
    int unsigned recv_stall_pct;  // chance per cycle that the sink stalls
    int unsigned quiet_cycles;

    ready_queue_scoreboard sb;

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    priority_ready_bitmap_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Monitors: note every accepted request, check every accepted result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(req_type_t'(s_tuser), s_tdata[5:0], s_tdata[13:6]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Sink: stall at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Source tasks
    // ------------------------------------------------------------------------

    // Offer one request; return at the edge where it is taken.
    task send_request(req_type_t op, logic [5:0] prio, logic [7:0] handle);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, handle, prio};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly well-formed traffic: fill and drain one focus group, pull the
    // current top level now and then, sprinkle requests over all levels.
    task run_random(int count);
        int          focus;
        req_type_t   op;
        logic [5:0]  prio;
        logic [7:0]  handle;
        int          pick;
        focus = $urandom_range(0, 7);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 6) focus = $urandom_range(0, 7);
            op   = ($urandom_range(0, 99) < 45) ? REQ_REMOVE : REQ_ADD;
            pick = $urandom_range(0, 99);
            if (op == REQ_REMOVE && pick < 25)
                prio = sb.ready_top();
            else if (pick < 70)
                prio = 6'((focus << 3) + $urandom_range(0, 7));
            else
                prio = 6'($urandom_range(0, 63));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                handle = 8'h00;
            else if (pick < 10)
                handle = 8'hFF;
            else
                handle = 8'($urandom_range(0, 255));
            send_request(op, prio, handle);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 11;
        recv_stall_pct = 84;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-queue remove, field extremes, zero handle,
        // overwrite, group emptying, drain back to empty.
        send_request(REQ_REMOVE, 6'd5,  8'hFF);  // remove from an empty level
        send_request(REQ_ADD,    6'd63, 8'hFF);  // highest level, widest handle
        send_request(REQ_ADD,    6'd0,  8'h00);  // add with zero handle
        send_request(REQ_REMOVE, 6'd0,  8'hAA);  // returns zero, level cleared
        send_request(REQ_ADD,    6'd20, 8'hAA);
        send_request(REQ_ADD,    6'd20, 8'h55);  // overwrite the same slot
        send_request(REQ_REMOVE, 6'd20, 8'h00);
        send_request(REQ_REMOVE, 6'd20, 8'h00);  // slot cleared by the last remove
        send_request(REQ_ADD,    6'd9,  8'h01);
        send_request(REQ_ADD,    6'd10, 8'h80);
        send_request(REQ_ADD,    6'd7,  8'h7F);
        send_request(REQ_REMOVE, 6'd7,  8'h00);  // group 0 empties
        send_request(REQ_REMOVE, 6'd9,  8'h00);  // group 1 keeps level 10
        send_request(REQ_REMOVE, 6'd10, 8'h00);  // group 1 empties
        send_request(REQ_ADD,    6'd56, 8'hC3);
        send_request(REQ_ADD,    6'd8,  8'h3C);
        send_request(REQ_ADD,    6'd42, 8'hFE);
        send_request(REQ_REMOVE, 6'd8,  8'h00);
        send_request(REQ_REMOVE, 6'd42, 8'h00);
        send_request(REQ_REMOVE, 6'd56, 8'h00);
        send_request(REQ_REMOVE, 6'd63, 8'h00);  // queue empty again

        // Random: slow sink, then slow source, then full rate.
        run_random(ITEMS_PER_RUN);
        send_idle_pct  = 84;
        recv_stall_pct = 11;
        run_random(ITEMS_PER_RUN);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(ITEMS_PER_RUN);
        s_tvalid <= 1'b0;

        // Drain, then linger to catch any stray result items.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/prb_pkg.sv
rtl/prb_ctrl.sv
rtl/prb_datapath.sv
rtl/priority_ready_bitmap_top.sv
tb/tb_priority_ready_bitmap_top.sv
